// ===== sv/earrf_pkg.sv =====
// Shared widths, types and the exponent table of the edge-aware recursive row filter.
`default_nettype none

package earrf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DERIV_W  = 16;
   localparam int RATE_W   = 16;
   localparam int WEIGHT_W = 16;
   localparam int STORE_W  = 24;
   localparam int POS_W    = 6;
   localparam int TAB_W    = 17;

   // Reset value of the rate register: 1.0 in Q4.12.
   localparam logic [RATE_W-1:0] RATE_RESET = 16'd4096;
   // log2(e) in Q1.16.
   localparam logic [16:0] LOG2E_Q16 = 17'd94548;

   typedef logic [SAMPLE_W-1:0]        sample_type;
   typedef logic [DERIV_W-1:0]         deriv_type;
   typedef logic [RATE_W-1:0]          rate_type;
   typedef logic [WEIGHT_W-1:0]        weight_type;
   typedef logic signed [STORE_W-1:0]  store_type;
   typedef logic [POS_W-1:0]           pos_type;

   // 65536 * 2^(-idx/16), rounded, for idx 0 to 16.
   function automatic logic [TAB_W-1:0] pow2_neg(input logic [4:0] idx);
      logic [TAB_W-1:0] val;
      unique case (idx)
         5'd0:    val = 17'd65536;
         5'd1:    val = 17'd62757;
         5'd2:    val = 17'd60097;
         5'd3:    val = 17'd57549;
         5'd4:    val = 17'd55109;
         5'd5:    val = 17'd52773;
         5'd6:    val = 17'd50535;
         5'd7:    val = 17'd48393;
         5'd8:    val = 17'd46341;
         5'd9:    val = 17'd44376;
         5'd10:   val = 17'd42495;
         5'd11:   val = 17'd40693;
         5'd12:   val = 17'd38968;
         5'd13:   val = 17'd37316;
         5'd14:   val = 17'd35734;
         5'd15:   val = 17'd34219;
         5'd16:   val = 17'd32768;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== sv/earrf_weight.sv =====
// Four-stage pipeline that turns rate and derivative into the weight exp(-rate*d).
`default_nettype none

module earrf_weight (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  earrf_pkg::rate_type    rate,
   input  earrf_pkg::deriv_type   deriv,
   output logic                   done,
   output earrf_pkg::weight_type  weight
);
   import earrf_pkg::*;

   logic [31:0]      x_ff;
   logic [48:0]      y_prod;
   logic [32:0]      y_ff;
   logic [12:0]      n_hi;
   logic [3:0]       frac_j;
   logic [9:0]       frac_r;
   logic [TAB_W-1:0] t0;
   logic [TAB_W-1:0] t1;
   logic [11:0]      step;
   logic [21:0]      ip;
   logic [TAB_W-1:0] t0_ff;
   logic [21:0]      ip_ff;
   logic [4:0]       n_ff;
   logic             zero_ff;
   logic [TAB_W-1:0] t_val;
   logic [TAB_W-1:0] shifted;
   weight_type       weight_in;
   weight_type       weight_ff;
   logic [3:0]       vld_ff;

   // Stage two: scale by log2(e), leaving the exponent in Q.20.
   assign y_prod = 49'(x_ff) * 49'(LOG2E_Q16);

   // Stage three: integer part, table index and interpolation fraction.
   always_comb begin
      n_hi   = y_ff[32:20];
      frac_j = y_ff[19:16];
      frac_r = y_ff[15:6];
      t0     = pow2_neg({1'b0, frac_j});
      t1     = pow2_neg(5'({1'b0, frac_j}) + 5'd1);
      step   = 12'(t0 - t1);
      ip     = {10'b0, step} * {12'b0, frac_r};
   end

   // Stage four: interpolate, shift by the integer exponent and cap.
   always_comb begin
      t_val   = t0_ff - {5'b0, ip_ff[21:10]};
      shifted = t_val >> n_ff;
      if (zero_ff) begin
         weight_in = '0;
      end else if (shifted[TAB_W-1]) begin
         weight_in = '1;
      end else begin
         weight_in = shifted[WEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= 32'(rate) * 32'(deriv);
      y_ff      <= y_prod[48:16];
      t0_ff     <= t0;
      ip_ff     <= ip;
      n_ff      <= n_hi[4:0];
      zero_ff   <= (n_hi >= 13'd17);
      weight_ff <= weight_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[2:0], start};
      end
   end

   assign done   = vld_ff[3];
   assign weight = weight_ff;

endmodule

`default_nettype wire

// ===== sv/earrf_blend.sv =====
// Shared recursion step a + round(v * (b - a) / 65536), one multiply stage deep.
`default_nettype none

module earrf_blend (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  earrf_pkg::store_type   a,
   input  earrf_pkg::store_type   b,
   input  earrf_pkg::weight_type  v,
   output logic                   done,
   output earrf_pkg::store_type   result
);
   import earrf_pkg::*;

   localparam int PROD_W = STORE_W + WEIGHT_W + 2;

   logic signed [STORE_W:0]  diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] rnd;
   logic signed [PROD_W-1:0] quot;
   store_type                a_ff;
   logic                     done_ff;

   always_comb begin
      diff = {b[STORE_W-1], b} - {a[STORE_W-1], a};
      prod = diff * $signed({1'b0, v});
   end

   // Adding one half and shifting arithmetically rounds to nearest, with ties toward plus infinity.
   always_comb begin
      rnd  = prod_ff + PROD_W'(32768);
      quot = rnd >>> 16;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod;
      a_ff    <= a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
   end

   assign result = store_type'(a_ff + quot[STORE_W-1:0]);
   assign done   = done_ff;

endmodule

`default_nettype wire

// ===== sv/edge_aware_recursive_row_filter_unit.sv =====
// Top level of the edge-aware recursive row filter: sequencer, row memories and output register.
//
// Usage. Samples of one row arrive as beats on the req_ channel, each with its
// domain-transform derivative; the beat with req_row_end set closes the row.
// Every sample is weighted by exp(-rate*d), where rate comes from the single
// configuration register written through csr_write_enable / csr_write_data,
// and the causal pass result is stored as the sample arrives. After the
// closing beat the block walks the stored row from right to left for the
// anticausal pass, then sends one rsp_ beat per stored sample, left to right,
// with rsp_final_of_row on the last one. Samples beyond ROW_MAX are dropped.
// One sample is taken at a time: the next waits until the weight pipeline (four
// stages) and the blend multiplier are through with it. The backward pass steps
// through read, multiply and write states for each stored sample past the first,
// bounded by the single read port of the row memory; each result beat then goes
// through read, load and output states and leaves when the receiver is ready.
// While the receiver stalls, the pending beat holds in the output register and
// nothing else moves. Reset empties the row (the memory contents are not cleared,
// since only written entries are ever read) and sets the rate register to 1.0.
`default_nettype none

module edge_aware_recursive_row_filter_unit #(
   parameter int ROW_MAX = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  earrf_pkg::sample_type  req_sample_value,
   input  earrf_pkg::deriv_type   req_domain_derivative,
   input  logic                   req_row_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output earrf_pkg::sample_type  rsp_filtered_value,
   output earrf_pkg::pos_type     rsp_pixel_position,
   output logic                   rsp_final_of_row,
   input  logic                   csr_write_enable,
   input  earrf_pkg::rate_type    csr_write_data
);
   import earrf_pkg::*;

   localparam int AW = $clog2(ROW_MAX);
   localparam int CW = $clog2(ROW_MAX + 1);
   localparam int IW = (AW > POS_W) ? AW : POS_W;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_WEIGHT   = 4'd1;
   localparam logic [3:0] ST_FWD_WR   = 4'd2;
   localparam logic [3:0] ST_BWD_RD   = 4'd3;
   localparam logic [3:0] ST_BWD_MUL  = 4'd4;
   localparam logic [3:0] ST_BWD_WR   = 4'd5;
   localparam logic [3:0] ST_EMIT_RD  = 4'd6;
   localparam logic [3:0] ST_EMIT_LD  = 4'd7;
   localparam logic [3:0] ST_EMIT_OUT = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] idx_ff, idx_in;
   rate_type    rate_ff;
   sample_type  s_ff, s_in;
   logic        last_ff, last_in;
   weight_type  wgt_ff, wgt_in;
   store_type   carry_ff, carry_in;

   sample_type  rsp_value_ff, rsp_value_in;
   pos_type     rsp_pos_ff, rsp_pos_in;
   logic        rsp_final_ff, rsp_final_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Row memories: causal and then final results, and the per-sample weights.
   store_type   samples_mem [ROW_MAX];
   weight_type  weights_mem [ROW_MAX];
   store_type   rd_sample_ff;
   weight_type  rd_weight_ff;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic        wgt_wr_en;
   logic [AW-1:0] rd_addr;

   logic        weight_start;
   logic        weight_done;
   weight_type  weight_val;

   logic        blend_start;
   store_type   blend_a;
   store_type   blend_b;
   weight_type  blend_v;
   logic        blend_done;
   store_type   blend_res;

   logic        req_fire;
   logic        rsp_fire;
   logic        row_full;
   logic [IW-1:0] idx_wide;
   sample_type  sat_value;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid_ff && rsp_ready;
   assign row_full = (fill_ff == CW'(ROW_MAX));
   assign idx_wide = IW'(idx_ff);

   assign weight_start = req_fire;

   earrf_weight u_weight (
      .clock  (clock),
      .reset  (reset),
      .start  (weight_start),
      .rate   (rate_ff),
      .deriv  (req_domain_derivative),
      .done   (weight_done),
      .weight (weight_val)
   );

   earrf_blend u_blend (
      .clock  (clock),
      .reset  (reset),
      .start  (blend_start),
      .a      (blend_a),
      .b      (blend_b),
      .v      (blend_v),
      .done   (blend_done),
      .result (blend_res)
   );

   // Clamp a stored result to the 16-bit output range.
   always_comb begin
      if (rd_sample_ff[STORE_W-1]) begin
         sat_value = '0;
      end else if (|rd_sample_ff[STORE_W-2:SAMPLE_W]) begin
         sat_value = '1;
      end else begin
         sat_value = rd_sample_ff[SAMPLE_W-1:0];
      end
   end

   // The blend unit serves both passes. The first sample of a row is blended
   // with itself under a zero weight, which passes it unchanged and keeps the
   // carry of an earlier row out of the result.
   always_comb begin
      if (state_ff == ST_WEIGHT) begin
         blend_start = weight_done && !row_full;
         blend_a     = store_type'({{(STORE_W-SAMPLE_W){1'b0}}, s_ff});
         blend_b     = (fill_ff == '0) ? blend_a : carry_ff;
         blend_v     = (fill_ff == '0) ? '0 : weight_val;
      end else begin
         blend_start = (state_ff == ST_BWD_MUL);
         blend_a     = rd_sample_ff;
         blend_b     = carry_ff;
         blend_v     = rd_weight_ff;
      end
   end

   // Memory port selection.
   always_comb begin
      wr_en     = (state_ff == ST_FWD_WR) || (state_ff == ST_BWD_WR);
      wgt_wr_en = (state_ff == ST_FWD_WR);
      wr_addr   = (state_ff == ST_FWD_WR) ? fill_ff[AW-1:0] : (idx_ff - AW'(1));
      rd_addr   = (state_ff == ST_BWD_RD) ? (idx_ff - AW'(1)) : idx_ff;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      s_in         = s_ff;
      last_in      = last_ff;
      wgt_in       = wgt_ff;
      carry_in     = carry_ff;
      rsp_value_in = rsp_value_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_final_in = rsp_final_ff;
      rsp_valid_in = rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               s_in     = req_sample_value;
               last_in  = req_row_end;
               state_in = ST_WEIGHT;
            end
         end
         ST_WEIGHT: begin
            if (weight_done) begin
               wgt_in = weight_val;
               if (!row_full) begin
                  state_in = ST_FWD_WR;
               end else if (last_ff) begin
                  // A closing sample that finds the row full still ends the row.
                  idx_in   = AW'(ROW_MAX - 1);
                  state_in = ST_BWD_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FWD_WR: begin
            carry_in = blend_res;
            fill_in  = fill_ff + CW'(1);
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (fill_ff == '0) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               idx_in   = fill_ff[AW-1:0];
               state_in = ST_BWD_RD;
            end
         end
         ST_BWD_RD: begin
            state_in = ST_BWD_MUL;
         end
         ST_BWD_MUL: begin
            state_in = ST_BWD_WR;
         end
         ST_BWD_WR: begin
            carry_in = blend_res;
            if (idx_ff == AW'(1)) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               idx_in   = idx_ff - AW'(1);
               state_in = ST_BWD_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            rsp_value_in = sat_value;
            rsp_pos_in   = idx_wide[POS_W-1:0];
            rsp_final_in = (CW'(idx_ff) == (fill_ff - CW'(1)));
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_final_ff) begin
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_RESET;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            rate_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      last_ff      <= last_in;
      wgt_ff       <= wgt_in;
      carry_ff     <= carry_in;
      rsp_value_ff <= rsp_value_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_final_ff <= rsp_final_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         samples_mem[wr_addr] <= blend_res;
      end
      rd_sample_ff <= samples_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wgt_wr_en) begin
         weights_mem[fill_ff[AW-1:0]] <= wgt_ff;
      end
      rd_weight_ff <= weights_mem[idx_ff];
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_pixel_position = rsp_pos_ff;
   assign rsp_final_of_row   = rsp_final_ff;

   // The fill count never passes the row capacity.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(ROW_MAX))
      else $error("fill count beyond row capacity");

   // Every write state finds the blend result ready.
   a_blend_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FWD_WR || state_ff == ST_BWD_WR) |-> blend_done)
      else $error("memory write without blend result");

   // Input and output are never open at once.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result beat is pending");

   // The last beat of a row empties the row.
   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_final_of_row) |=> (fill_ff == '0 && req_ready))
      else $error("row not restarted after its last beat");

   // The backward pass never reads to the left of the row.
   a_bwd_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BWD_RD) |-> (idx_ff != '0))
      else $error("backward pass index at zero");

endmodule

`default_nettype wire
